@@ src/swsr_pkg.sv @@
// Shared types and constants for the single-wire sensor reader.
`default_nettype none

package swsr_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// Position of the checksum byte within the five-byte frame.
	localparam logic [2:0] LAST_BYTE = 3'd4;

	localparam logic [15:0] START_LOW_RST  = 16'd20000;
	localparam logic [7:0]  RELEASE_RST    = 8'd30;
	localparam logic [7:0]  SETTLE_RST     = 8'd40;
	localparam logic [7:0]  ACK_RST        = 8'd80;
	localparam logic [7:0]  BIT_SAMPLE_RST = 8'd40;
	localparam logic [15:0] TIMEOUT_RST    = 16'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_LOW  = 3'd0,
		REG_RELEASE    = 3'd1,
		REG_SETTLE     = 3'd2,
		REG_ACK        = 3'd3,
		REG_BIT_SAMPLE = 3'd4,
		REG_TIMEOUT    = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_DRIVE   = 4'd1,
		PH_RELEASE = 4'd2,
		PH_SETTLE  = 4'd3,
		PH_ACKHI   = 4'd4,
		PH_ACKEND  = 4'd5,
		PH_RISE    = 4'd6,
		PH_SAMPLE  = 4'd7,
		PH_FALL    = 4'd8
	} phase_t;

	typedef struct packed {
		logic [15:0] start_low_us;
		logic [7:0]  release_us;
		logic [7:0]  settle_us;
		logic [7:0]  ack_us;
		logic [7:0]  bit_sample_us;
		logic [15:0] timeout_us;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       byte_valid;
		logic [7:0] data_byte;
		logic [2:0] byte_index;
		logic       response_ok;
		logic       done;
		logic       checksum_ok;
		logic       timed_out;
	} res_t;

endpackage

`default_nettype wire

@@ src/swsr_cfg.sv @@
// Configuration register file with reset defaults.
`default_nettype none

module swsr_cfg
	import swsr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_us  <= START_LOW_RST;
			cfg_q.release_us    <= RELEASE_RST;
			cfg_q.settle_us     <= SETTLE_RST;
			cfg_q.ack_us        <= ACK_RST;
			cfg_q.bit_sample_us <= BIT_SAMPLE_RST;
			cfg_q.timeout_us    <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_START_LOW:  cfg_q.start_low_us  <= cfg_data;
				REG_RELEASE:    cfg_q.release_us    <= cfg_data[7:0];
				REG_SETTLE:     cfg_q.settle_us     <= cfg_data[7:0];
				REG_ACK:        cfg_q.ack_us        <= cfg_data[7:0];
				REG_BIT_SAMPLE: cfg_q.bit_sample_us <= cfg_data[7:0];
				REG_TIMEOUT:    cfg_q.timeout_us    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ src/swsr_fsm.sv @@
// Reading sequencer: phase, wait timer, bit and byte assembly, checksum.
`default_nettype none

module swsr_fsm
	import swsr_pkg::*;
#(
	parameter int unsigned TIMER_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step_en,
	input  wire logic req_type,
	input  wire logic line_level,
	input  wire cfg_t cfg,
	output res_t      res
);

	localparam int CW = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
	localparam logic [TIMER_BITS-1:0] TMAX = '1;

	phase_t                phase_q, phase_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc, lim_t;
	logic [2:0]            bit_q, bit_d;
	logic [2:0]            byte_q, byte_d;
	logic [7:0]            shift_q, shift_d;
	logic [7:0]            sum_q, sum_d;
	logic                  ack_q, ack_d;
	logic                  tmo_q, tmo_d;
	logic [15:0]           lim_raw;
	logic [CW-1:0]         lim_ext;
	logic                  hit, line_edge;
	logic                  emit, done, ck;

	// Delay for the current phase; the edge waits use the timeout.
	always_comb begin
		case (phase_q)
			PH_DRIVE:   lim_raw = cfg.start_low_us;
			PH_RELEASE: lim_raw = {8'd0, cfg.release_us};
			PH_SETTLE:  lim_raw = {8'd0, cfg.settle_us};
			PH_ACKHI:   lim_raw = {8'd0, cfg.ack_us};
			PH_SAMPLE:  lim_raw = {8'd0, cfg.bit_sample_us};
			default:    lim_raw = cfg.timeout_us;
		endcase
	end

	// The timer saturates, so a limit beyond its range acts as the maximum.
	assign lim_ext   = CW'(lim_raw);
	assign lim_t     = (lim_ext > CW'(TMAX)) ? TMAX : TIMER_BITS'(lim_ext);
	assign timer_inc = (timer_q == TMAX) ? timer_q : timer_q + 1'b1;
	assign hit       = (timer_inc >= lim_t);
	assign line_edge = (phase_q == PH_RISE) ? line_level : !line_level;

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		bit_d   = bit_q;
		byte_d  = byte_q;
		shift_d = shift_q;
		sum_d   = sum_q;
		ack_d   = ack_q;
		tmo_d   = tmo_q;
		emit    = 1'b0;
		done    = 1'b0;
		ck      = 1'b0;
		if (req_type) begin
			// A start abandons any reading in progress.
			phase_d = PH_DRIVE;
			timer_d = '0;
			bit_d   = '0;
			byte_d  = '0;
			shift_d = '0;
			sum_d   = '0;
			ack_d   = 1'b0;
			tmo_d   = 1'b0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_DRIVE, PH_RELEASE: begin
					if (hit) begin
						phase_d = (phase_q == PH_DRIVE) ? PH_RELEASE : PH_SETTLE;
						timer_d = '0;
					end else begin
						timer_d = timer_inc;
					end
				end
				PH_SETTLE: begin
					if (hit) begin
						timer_d = '0;
						if (!line_level) begin
							phase_d = PH_ACKHI;
						end else begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end
					end else begin
						timer_d = timer_inc;
					end
				end
				PH_ACKHI: begin
					if (hit) begin
						timer_d = '0;
						if (line_level) begin
							ack_d   = 1'b1;
							phase_d = PH_ACKEND;
						end else begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end
					end else begin
						timer_d = timer_inc;
					end
				end
				PH_ACKEND, PH_RISE, PH_FALL: begin
					if (line_edge) begin
						timer_d = '0;
						if (phase_q == PH_ACKEND) begin
							phase_d = PH_RISE;
						end else if (phase_q == PH_RISE) begin
							phase_d = PH_SAMPLE;
						end else if (bit_q != 3'd0) begin
							phase_d = PH_RISE;
						end else begin
							// The bit counter wrapped, so a whole byte is in.
							emit = 1'b1;
							if (byte_q < LAST_BYTE) begin
								sum_d   = sum_q + shift_q;
								byte_d  = byte_q + 3'd1;
								shift_d = '0;
								phase_d = PH_RISE;
							end else begin
								ck      = (sum_q == shift_q);
								done    = 1'b1;
								phase_d = PH_IDLE;
							end
						end
					end else if (hit) begin
						tmo_d   = 1'b1;
						done    = 1'b1;
						phase_d = PH_IDLE;
						timer_d = '0;
					end else begin
						timer_d = timer_inc;
					end
				end
				PH_SAMPLE: begin
					if (hit) begin
						shift_d = {shift_q[6:0], line_level};
						bit_d   = bit_q + 3'd1;
						phase_d = PH_FALL;
						timer_d = '0;
					end else begin
						timer_d = timer_inc;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					timer_d = '0;
				end
			endcase
		end
	end

	always_comb begin
		res.drive_low   = (phase_d == PH_DRIVE);
		res.busy        = (phase_d != PH_IDLE);
		res.byte_valid  = emit;
		res.data_byte   = emit ? shift_q : 8'd0;
		res.byte_index  = emit ? byte_q : 3'd0;
		res.response_ok = ack_d;
		res.done        = done;
		res.checksum_ok = ck;
		res.timed_out   = tmo_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			sum_q   <= '0;
			ack_q   <= 1'b0;
			tmo_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			shift_q <= shift_d;
			sum_q   <= sum_d;
			ack_q   <= ack_d;
			tmo_q   <= tmo_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_byte_from_fall: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.byte_valid |-> phase_q == PH_FALL && !req_type)
		else $error("byte completed outside the falling-edge wait");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.done |=> phase_q == PH_IDLE)
		else $error("reading ended but sequencer did not return to idle");

	a_checksum_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.checksum_ok |-> res.done && res.byte_valid
			&& res.byte_index == LAST_BYTE)
		else $error("checksum verdict outside the last byte");

	a_timeout_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && $rose(tmo_d) && !req_type |-> res.done && !res.byte_valid)
		else $error("timeout did not end the reading cleanly");
`endif

endmodule

`default_nettype wire

@@ src/single_wire_sensor_reader.sv @@
// Top level of the single-wire sensor reader: input register, sequencer, result register.
`default_nettype none

// Each input beat is either a one-microsecond tick carrying the sampled data
// line or a start request. The block takes one beat per clock cycle while the
// result register is empty or drained. A beat waits in the input register until
// the result register is empty or drained; the sequencer step logic then writes
// its result into the result register, where it is shown until it is taken.
// When the result register is full and not taken, an empty input register still
// accepts one more beat. Configuration registers are plain writes and take
// effect on the next beat processed; write them only while no reading runs.
// Timers are TIMER_BITS wide and saturate; longer configured delays act as
// the maximum. There is no clearing pass after reset.
module single_wire_sensor_reader
	import swsr_pkg::*;
#(
	parameter int unsigned TIMER_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic                  req_type,
	input  wire logic                  line_level,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output logic                       drive_low,
	output logic                       busy_res,
	output logic                       byte_valid,
	output logic [7:0]                 data_byte,
	output logic [2:0]                 byte_index,
	output logic                       response_ok,
	output logic                       done_res,
	output logic                       checksum_ok,
	output logic                       timed_out
);

	cfg_t cfg;
	res_t step_res;
	res_t res_s2;
	logic valid_s1, req_type_s1, line_level_s1;
	logic res_valid_s2;
	logic adv, step_en;

	// The pipeline moves whenever the result register is empty or drained.
	assign adv       = !res_valid_s2 || res_ready;
	assign req_ready = !valid_s1 || adv;
	assign step_en   = valid_s1 && adv;

	swsr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	swsr_fsm #(
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.req_type   (req_type_s1),
		.line_level (line_level_s1),
		.cfg        (cfg),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				res_valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_type_s1   <= req_type;
			line_level_s1 <= line_level;
		end
		if (step_en) begin
			res_s2 <= step_res;
		end
	end

	assign res_valid   = res_valid_s2;
	assign drive_low   = res_s2.drive_low;
	assign busy_res    = res_s2.busy;
	assign byte_valid  = res_s2.byte_valid;
	assign data_byte   = res_s2.data_byte;
	assign byte_index  = res_s2.byte_index;
	assign response_ok = res_s2.response_ok;
	assign done_res    = res_s2.done;
	assign checksum_ok = res_s2.checksum_ok;
	assign timed_out   = res_s2.timed_out;

endmodule

`default_nettype wire

@@ verif/single_wire_sensor_reader_checker.sv @@
// Checker for the single-wire sensor reader: predicts each reading beat and compares results.
`timescale 1ns / 1ps

module single_wire_sensor_reader_checker
	import swsr_pkg::*;
#(
	parameter int unsigned TIMER_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  req_valid,
	input  wire logic                  req_ready,
	input  wire logic                  req_type,
	input  wire logic                  line_level,
	input  wire logic                  res_valid,
	input  wire logic                  res_ready,
	input  wire logic                  drive_low,
	input  wire logic                  busy_res,
	input  wire logic                  byte_valid,
	input  wire logic [7:0]            data_byte,
	input  wire logic [2:0]            byte_index,
	input  wire logic                  response_ok,
	input  wire logic                  done_res,
	input  wire logic                  checksum_ok,
	input  wire logic                  timed_out,
	output int                         mismatches,
	output int                         outstanding
);

	localparam int unsigned TIMER_MAX = (1 << TIMER_BITS) - 1;

	cfg_t                  cfg;
	phase_t                ph;
	logic [TIMER_BITS-1:0] elapsed;
	logic [2:0]            bits_in;
	logic [2:0]            bytes_in;
	logic [7:0]            shift_in;
	logic [9:0]            frame_sum;
	logic                  ack_flag;
	logic                  timeout_flag;

	res_t expected_readings[$];
	int   errors;
	int   reading_no;

	// The timer saturates, and a limit beyond its range acts as the range.
	function automatic bit timer_expired(input logic [15:0] lim);
		int unsigned cap;
		cap = (32'(lim) > TIMER_MAX) ? TIMER_MAX : 32'(lim);
		if (32'(elapsed) != TIMER_MAX)
			elapsed++;
		return 32'(elapsed) >= cap;
	endfunction

	function automatic void go_to(input phase_t p);
		ph = p;
		elapsed = '0;
	endfunction

	function automatic void restart_frame();
		elapsed = '0;
		bits_in = '0;
		bytes_in = '0;
		shift_in = '0;
		frame_sum = '0;
		ack_flag = 1'b0;
		timeout_flag = 1'b0;
	endfunction

	function automatic res_t predict_reading(input logic start, input logic lvl);
		res_t r;
		logic edge_seen;
		r = '0;
		if (start) begin
			restart_frame();
			go_to(PH_DRIVE);
		end else begin
			case (ph)
				PH_IDLE: ;
				PH_DRIVE: if (timer_expired(cfg.start_low_us)) go_to(PH_RELEASE);
				PH_RELEASE: if (timer_expired(16'(cfg.release_us))) go_to(PH_SETTLE);
				PH_SETTLE: begin
					if (timer_expired(16'(cfg.settle_us))) begin
						if (!lvl) begin
							go_to(PH_ACKHI);
						end else begin
							go_to(PH_IDLE);
							r.done = 1'b1;
						end
					end
				end
				PH_ACKHI: begin
					if (timer_expired(16'(cfg.ack_us))) begin
						if (lvl) begin
							ack_flag = 1'b1;
							go_to(PH_ACKEND);
						end else begin
							go_to(PH_IDLE);
							r.done = 1'b1;
						end
					end
				end
				PH_ACKEND, PH_RISE, PH_FALL: begin
					edge_seen = (ph == PH_RISE) ? lvl : !lvl;
					if (edge_seen) begin
						if (ph == PH_ACKEND) begin
							go_to(PH_RISE);
						end else if (ph == PH_RISE) begin
							go_to(PH_SAMPLE);
						end else if (bits_in != 3'd0) begin
							go_to(PH_RISE);
						end else begin
							// Eight bits have wrapped the bit counter: the byte is complete.
							r.byte_valid = 1'b1;
							r.data_byte = shift_in;
							r.byte_index = bytes_in;
							if (bytes_in < LAST_BYTE) begin
								frame_sum = frame_sum + 10'(shift_in);
								bytes_in++;
								shift_in = '0;
								go_to(PH_RISE);
							end else begin
								r.checksum_ok = (frame_sum[7:0] == shift_in);
								r.done = 1'b1;
								go_to(PH_IDLE);
							end
						end
					end else if (timer_expired(cfg.timeout_us)) begin
						timeout_flag = 1'b1;
						r.done = 1'b1;
						go_to(PH_IDLE);
					end
				end
				PH_SAMPLE: begin
					if (timer_expired(16'(cfg.bit_sample_us))) begin
						shift_in = {shift_in[6:0], lvl};
						bits_in++;
						go_to(PH_FALL);
					end
				end
				default: go_to(PH_IDLE);
			endcase
		end
		r.drive_low = (ph == PH_DRIVE);
		r.busy = (ph != PH_IDLE);
		r.response_ok = ack_flag;
		r.timed_out = timeout_flag;
		return r;
	endfunction

	function automatic string describe(input res_t r);
		return $sformatf({"drive=%b busy=%b byte_valid=%b byte=%h index=%0d ack=%b ",
			"done=%b sum_ok=%b timed_out=%b"}, r.drive_low, r.busy, r.byte_valid,
			r.data_byte, r.byte_index, r.response_ok, r.done, r.checksum_ok, r.timed_out);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t seen;
		res_t want;
		if (!arst_n) begin
			cfg = '{start_low_us: START_LOW_RST, release_us: RELEASE_RST,
				settle_us: SETTLE_RST, ack_us: ACK_RST,
				bit_sample_us: BIT_SAMPLE_RST, timeout_us: TIMEOUT_RST};
			ph = PH_IDLE;
			restart_frame();
			expected_readings.delete();
			errors = 0;
			reading_no = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_START_LOW:  cfg.start_low_us = cfg_data;
					REG_RELEASE:    cfg.release_us = cfg_data[7:0];
					REG_SETTLE:     cfg.settle_us = cfg_data[7:0];
					REG_ACK:        cfg.ack_us = cfg_data[7:0];
					REG_BIT_SAMPLE: cfg.bit_sample_us = cfg_data[7:0];
					REG_TIMEOUT:    cfg.timeout_us = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				expected_readings.push_back(predict_reading(req_type, line_level));
			if (res_valid && res_ready) begin
				seen = {drive_low, busy_res, byte_valid, data_byte, byte_index,
					response_ok, done_res, checksum_ok, timed_out};
				if (expected_readings.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result %0d arrived with nothing expected: %s",
							reading_no, describe(seen));
				end else begin
					want = expected_readings.pop_front();
					if (seen !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("result %0d mismatch, expected %s", reading_no,
								describe(want));
							$display("    actual %s", describe(seen));
						end
					end
				end
				reading_no++;
			end
			mismatches <= errors;
			outstanding <= expected_readings.size();
		end
	end

endmodule

@@ verif/single_wire_sensor_reader_tb.sv @@
// Testbench top for the single-wire sensor reader: sensor stimulus, result sink and verdict.
`timescale 1ns / 1ps

module single_wire_sensor_reader_tb;
	import swsr_pkg::*;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_START = 1'b1;
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_HI = 3'd7;

	typedef enum int {
		FRAME_OK,
		FRAME_BAD_SUM,
		FRAME_NO_ACK_LOW,
		FRAME_NO_ACK_HIGH,
		FRAME_TIMEOUT,
		FRAME_RESTART
	} frame_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_ready;
	logic                  req_type;
	logic                  line_level;
	logic                  res_valid;
	logic                  res_ready;
	logic                  drive_low;
	logic                  busy_res;
	logic                  byte_valid;
	logic [7:0]            data_byte;
	logic [2:0]            byte_index;
	logic                  response_ok;
	logic                  done_res;
	logic                  checksum_ok;
	logic                  timed_out;
	int                    mismatches;
	int                    outstanding;

	cfg_t shadow_cfg;
	int   beats_sent = 0;
	int   calm_beats = 0;
	bit   counting = 1'b0;

	single_wire_sensor_reader dut (.*);

	single_wire_sensor_reader_checker reading_check (.*);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	// A delay or timeout of zero lasts one tick.
	function automatic int ticks_of(input int v);
		return (v == 0) ? 1 : v;
	endfunction

	task automatic send_beat(input logic kind, input logic lvl);
		int gap;
		if (calm_beats > 0) begin
			gap = 0;
			calm_beats--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 99) < 3)
				calm_beats = $urandom_range(50, 150);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		line_level <= lvl;
		do @(posedge clk); while (!req_ready);
		if (counting)
			beats_sent++;
	endtask

	task automatic tick(input logic lvl);
		send_beat(REQ_TICK, lvl);
	endtask

	// Wait for all results to come back, with the input side idle.
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input cfg_t c);
		drain();
		repeat (3) @(posedge clk);
		shadow_cfg = c;
		write_reg(REG_START_LOW, c.start_low_us);
		write_reg(REG_RELEASE, 16'(c.release_us));
		write_reg(REG_SETTLE, 16'(c.settle_us));
		write_reg(REG_ACK, 16'(c.ack_us));
		write_reg(REG_BIT_SAMPLE, 16'(c.bit_sample_us));
		write_reg(REG_TIMEOUT, c.timeout_us);
		write_reg(coin() ? SPARE_REG_HI : SPARE_REG_LO, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Non-edge ticks at idle_lvl, never enough to time out, then the edge.
	task automatic await_edge(input logic idle_lvl);
		int lim;
		int k;
		lim = ticks_of(shadow_cfg.timeout_us) - 1;
		if ($urandom_range(0, 99) == 0 && lim <= 400)
			k = lim;
		else
			k = $urandom_range(0, (lim < 3) ? lim : 3);
		repeat (k) tick(idle_lvl);
		tick(!idle_lvl);
	endtask

	task automatic break_off(input frame_kind_t kind, input logic idle_lvl);
		if (kind == FRAME_TIMEOUT)
			repeat (ticks_of(shadow_cfg.timeout_us)) tick(idle_lvl);
		else
			repeat ($urandom_range(0, 2)) tick(idle_lvl);
	endtask

	// One sensor transaction as the line would show it, tick by tick.
	task automatic play_frame(input frame_kind_t kind);
		logic [7:0] frame [5];
		int stop_at;
		bit in_fall;
		bit cut;
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 9))
				0: frame[i] = 8'h00;
				1: frame[i] = 8'hFF;
				default: frame[i] = 8'($urandom);
			endcase
		end
		frame[4] = frame[0] + frame[1] + frame[2] + frame[3];
		if (kind == FRAME_BAD_SUM)
			frame[4] = frame[4] + 8'($urandom_range(1, 255));
		stop_at = $urandom_range(0, 40) - 1;
		in_fall = coin();
		cut = (kind == FRAME_TIMEOUT || kind == FRAME_RESTART);

		send_beat(REQ_START, coin());
		repeat (ticks_of(shadow_cfg.start_low_us)) tick(coin());
		repeat (ticks_of(shadow_cfg.release_us)) tick(coin());
		repeat (ticks_of(shadow_cfg.settle_us) - 1) tick(coin());
		tick(kind == FRAME_NO_ACK_LOW);
		if (kind == FRAME_NO_ACK_LOW)
			return;
		repeat (ticks_of(shadow_cfg.ack_us) - 1) tick(coin());
		tick(kind != FRAME_NO_ACK_HIGH);
		if (kind == FRAME_NO_ACK_HIGH)
			return;
		if (cut && stop_at < 0) begin
			break_off(kind, 1'b1);
			return;
		end
		await_edge(1'b1);
		for (int n = 0; n < 40; n++) begin
			if (cut && stop_at == n && !in_fall) begin
				break_off(kind, 1'b0);
				return;
			end
			await_edge(1'b0);
			repeat (ticks_of(shadow_cfg.bit_sample_us) - 1) tick(coin());
			tick(frame[n / 8][7 - (n % 8)]);
			if (cut && stop_at == n && in_fall) begin
				break_off(kind, 1'b1);
				return;
			end
			await_edge(1'b1);
		end
	endtask

	// Result side: random stalls, calm stretches, and one long hold-off that
	// backs the block up into its input.
	initial begin : result_sink
		int  run_left;
		int  gap_left;
		int  taken;
		bit  held;
		run_left = 0;
		gap_left = 0;
		taken = 0;
		held = 1'b0;
		res_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready)
				taken++;
			if (!held && taken >= 400) begin
				held = 1'b1;
				gap_left = 600;
				run_left = 0;
			end
			if (gap_left == 0 && run_left == 0) begin
				run_left = ($urandom_range(0, 99) < 8) ? 200 : $urandom_range(1, 20);
				gap_left = pick_gap();
			end
			if (gap_left > 0) begin
				gap_left--;
				res_ready <= 1'b0;
			end else begin
				run_left--;
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		#(200_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		cfg_t c;
		int   phase_end;
		req_valid <= 1'b0;
		req_type <= REQ_TICK;
		line_level <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_START_LOW;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every delay at one tick and the shortest timeout.
		c = '{start_low_us: 16'd0, release_us: 8'd0, settle_us: 8'd0, ack_us: 8'd0,
			bit_sample_us: 8'd0, timeout_us: 16'd1};
		set_config(c);
		tick(1'b0);
		tick(1'b1);
		// Line high where the acknowledge must be low.
		send_beat(REQ_START, 1'b1);
		tick(1'b0);
		tick(1'b1);
		tick(1'b1);
		// Acknowledge low seen, but the line stays low for the high half.
		send_beat(REQ_START, 1'b0);
		tick(1'b1);
		tick(1'b0);
		tick(1'b0);
		tick(1'b0);
		// Good acknowledge, then no falling edge before the timeout.
		send_beat(REQ_START, 1'b1);
		tick(1'b0);
		tick(1'b0);
		tick(1'b0);
		tick(1'b1);
		tick(1'b1);
		// A start while the line is being released restarts the reading,
		// which then times out waiting for the first bit's rising edge.
		send_beat(REQ_START, 1'b0);
		tick(1'b1);
		send_beat(REQ_START, 1'b1);
		tick(1'b0);
		tick(1'b0);
		tick(1'b0);
		tick(1'b1);
		tick(1'b0);
		tick(1'b0);

		for (int ph = 0; beats_sent < 1100; ph++) begin
			if (ph == 1) begin
				c = '{start_low_us: 16'hFFFF, release_us: 8'hFF, settle_us: 8'hFF,
					ack_us: 8'hFF, bit_sample_us: 8'hFF, timeout_us: 16'hFFFF};
				counting = 1'b0;
			end else begin
				c.start_low_us = 16'($urandom_range(0, 4));
				c.release_us = 8'($urandom_range(0, 3));
				c.settle_us = 8'($urandom_range(0, 3));
				c.ack_us = 8'($urandom_range(0, 3));
				c.bit_sample_us = 8'($urandom_range(0, 4));
				case ($urandom_range(0, 4))
					0: c.timeout_us = 16'd1;
					1: c.timeout_us = 16'($urandom_range(100, 400));
					default: c.timeout_us = 16'($urandom_range(2, 6));
				endcase
				counting = 1'b1;
			end
			set_config(c);
			phase_end = beats_sent + 200;
			if (ph != 1) begin
				while (beats_sent < phase_end) begin
					case ($urandom_range(0, 19))
						0, 1, 2, 3: begin
							repeat ($urandom_range(1, 12))
								send_beat(($urandom_range(0, 15) == 0) ? REQ_START : REQ_TICK,
									coin());
						end
						4: drain();
						default: play_frame(frame_kind_t'($urandom_range(0, FRAME_RESTART)));
					endcase
				end
				// A complete frame leaves the block idle for the next register writes.
				play_frame(FRAME_OK);
			end else begin
				// With the longest delays only the start of the drive phase is played.
				send_beat(REQ_START, coin());
				repeat (40) tick(coin());
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
